>>> design/spc_pkg.sv
// ----------------------------------------------------------------------------
// Sphere/plane contact test package
// Beat types of the input and result channels and shared fixed point helpers.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic                     kind_first;
    logic signed [DATA_W-1:0] first_x;
    logic signed [DATA_W-1:0] first_y;
    logic signed [DATA_W-1:0] first_z;
    logic signed [DATA_W-1:0] first_scalar;
    logic                     kind_second;
    logic signed [DATA_W-1:0] second_x;
    logic signed [DATA_W-1:0] second_y;
    logic signed [DATA_W-1:0] second_z;
    logic signed [DATA_W-1:0] second_scalar;
  } in_beat_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] depth;
    logic signed [DATA_W-1:0] normal_x;
    logic signed [DATA_W-1:0] normal_y;
    logic signed [DATA_W-1:0] normal_z;
    logic signed [DATA_W-1:0] point_first_x;
    logic signed [DATA_W-1:0] point_first_y;
    logic signed [DATA_W-1:0] point_first_z;
    logic signed [DATA_W-1:0] point_second_x;
    logic signed [DATA_W-1:0] point_second_y;
    logic signed [DATA_W-1:0] point_second_z;
  } out_beat_t;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  function automatic logic signed [65:0] ext66(input logic signed [31:0] a);
    return {{34{a[31]}}, a};
  endfunction

  function automatic logic signed [65:0] wext66(input logic signed [63:0] a);
    return {{2{a[63]}}, a};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] mul64(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] ax;
    logic signed [63:0] bx;
    ax = {{32{a[31]}}, a};
    bx = {{32{b[31]}}, b};
    return ax * bx;
  endfunction

endpackage

>>> design/sphere_plane_contact_test_core.sv
// Throughput: one pair per cycle; busy is always low.
// The depth is set by the 32-stage square root and the FRAC_BITS + 1 stage divider.
// Reset (rst_n low, synchronous) clears all valid bits; data in flight is dropped.
// ----------------------------------------------------------------------------
// Sphere/plane contact test core
// Narrow-phase contact of two colliders, each a sphere or a plane, Q format.
// ----------------------------------------------------------------------------
module sphere_plane_contact_test_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spc_pkg::in_beat_t in_data,
  output logic              out_strobe,
  output spc_pkg::out_beat_t out_data
);

  localparam int SQ_LAT  = 32;
  localparam int DIV_LAT = FRAC_BITS + 1;
  localparam int LATENCY = FRAC_BITS + 40;

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  typedef struct packed {
    logic mode_ss;
    logic mode_sp;
    logic neg;
    logic hit_ss;
    logic hit_sp;
    logic dist_zero;
    logic [2:0][31:0] d;
    logic [2:0][31:0] c1;
    logic [2:0][31:0] c2;
    logic [2:0][31:0] n_pl;
    logic [2:0][31:0] c_pl;
    logic [2:0][31:0] pt_pl;
    logic [2:0][31:0] nrm;
    logic [2:0][31:0] absd;
    logic [2:0]       dsign;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic signed [31:0] rs;
    logic signed [31:0] rad;
    logic signed [31:0] off;
    logic signed [31:0] dp;
    logic signed [31:0] depth_sp;
    logic signed [31:0] depth_ss;
    logic [31:0] root_len;
    logic [2:0][63:0] p;
    logic [2:0][63:0] sq;
    logic [2:0][63:0] prod;
    logic [2:0][63:0] m1;
    logic [2:0][63:0] m2;
    logic [63:0] rsq;
    logic [63:0] dsq;
  } pipe_t;

  pipe_t st1_r, st1_nxt, st2_r, st2_nxt, st3_r, st3_nxt;
  pipe_t e_r, e_nxt, n_r, n_nxt, m_r, m_nxt;
  pipe_t dl1_r [0:SQ_LAT-1];
  pipe_t dl2_r [0:DIV_LAT-1];
  logic  v1_r, v2_r, v3_r, ve_r, vn_r, vm_r;
  logic  vd1_r [0:SQ_LAT-1];
  logic  vd2_r [0:DIV_LAT-1];

  logic [31:0]              root;
  logic [2:0][FRAC_BITS:0]  quo;

  spc_pkg::out_beat_t out_nxt, out_r;
  logic               strobe_r;

  assign busy = 1'b0;

  // Stage 1: role selection, center differences, radius sum, plane dot terms.
  always_comb begin
    logic ka, kb;
    logic [2:0][31:0] sc, pl;
    ka = in_data.kind_first;
    kb = in_data.kind_second;
    st1_nxt = '0;
    st1_nxt.mode_ss = !ka && !kb;
    st1_nxt.mode_sp = ka ^ kb;
    st1_nxt.neg     = ka && !kb;
    st1_nxt.c1 = {in_data.first_z, in_data.first_y, in_data.first_x};
    st1_nxt.c2 = {in_data.second_z, in_data.second_y, in_data.second_x};
    st1_nxt.r1 = in_data.first_scalar;
    st1_nxt.r2 = in_data.second_scalar;
    sc = ka ? st1_nxt.c2 : st1_nxt.c1;
    pl = ka ? st1_nxt.c1 : st1_nxt.c2;
    st1_nxt.c_pl = sc;
    st1_nxt.n_pl = pl;
    st1_nxt.rad  = ka ? in_data.second_scalar : in_data.first_scalar;
    st1_nxt.off  = ka ? in_data.first_scalar : in_data.second_scalar;
    st1_nxt.rs   = spc_pkg::sat32(spc_pkg::ext66(st1_nxt.r1) +
                                  spc_pkg::ext66(st1_nxt.r2));
    for (int i = 0; i < 3; i++) begin
      st1_nxt.d[i] = spc_pkg::sat32(spc_pkg::ext66($signed(st1_nxt.c2[i])) -
                                    spc_pkg::ext66($signed(st1_nxt.c1[i])));
      st1_nxt.p[i] = spc_pkg::mul64($signed(sc[i]), $signed(pl[i]));
    end
  end

  // Stage 2: squares, and the signed plane distance.
  always_comb begin
    logic signed [65:0] acc;
    st2_nxt = st1_r;
    acc = -spc_pkg::ext66(st1_r.off);
    for (int i = 0; i < 3; i++) begin
      st2_nxt.sq[i] = spc_pkg::mul64($signed(st1_r.d[i]), $signed(st1_r.d[i]));
      acc = acc + spc_pkg::wext66($signed(st1_r.p[i]) >>> FRAC_BITS);
    end
    st2_nxt.rsq = spc_pkg::mul64(st1_r.rs, st1_r.rs);
    st2_nxt.dp  = spc_pkg::sat32(acc);
  end

  // Stage 3: squared distance test, plane test and projection products.
  always_comb begin
    logic [32:0] ad;
    st3_nxt = st2_r;
    st3_nxt.dsq    = st2_r.sq[0] + st2_r.sq[1] + st2_r.sq[2];
    st3_nxt.hit_ss = st3_nxt.dsq < st2_r.rsq;
    ad = st2_r.dp[31] ? 33'd0 - {st2_r.dp[31], st2_r.dp} : {1'b0, st2_r.dp};
    st3_nxt.hit_sp = $signed({1'b0, ad}) <= $signed({{2{st2_r.rad[31]}}, st2_r.rad});
    st3_nxt.depth_sp = spc_pkg::sat32(spc_pkg::ext66(st2_r.rad) - $signed({33'd0, ad}));
    for (int i = 0; i < 3; i++) begin
      st3_nxt.prod[i] = spc_pkg::mul64($signed(st2_r.n_pl[i]), st2_r.dp);
    end
  end

  spc_isqrt u_isqrt (
    .clk      (clk),
    .rad_in   (st3_r.dsq),
    .root_out (root)
  );

  // Stage E: depth of the sphere pair, divider operands, plane contact point.
  always_comb begin
    e_nxt = dl1_r[SQ_LAT-1];
    e_nxt.root_len  = root;
    e_nxt.dist_zero = root == 32'd0;
    e_nxt.depth_ss  = spc_pkg::sat32(spc_pkg::ext66(e_nxt.rs) - $signed({34'd0, root}));
    for (int i = 0; i < 3; i++) begin
      e_nxt.dsign[i] = e_nxt.d[i][31];
      e_nxt.absd[i]  = e_nxt.d[i][31] ? 32'd0 - e_nxt.d[i] : e_nxt.d[i];
      e_nxt.pt_pl[i] = spc_pkg::sat32(spc_pkg::ext66($signed(e_nxt.c_pl[i])) -
                         spc_pkg::wext66($signed(e_nxt.prod[i]) >>> FRAC_BITS));
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_div
      spc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk     (clk),
        .num_in  (e_r.absd[g]),
        .den_in  (e_r.root_len),
        .quo_out (quo[g])
      );
    end
  endgenerate

  // Stage N: signed normal; coincident centers give the x axis.
  always_comb begin
    n_nxt = dl2_r[DIV_LAT-1];
    for (int i = 0; i < 3; i++) begin
      if (n_nxt.dist_zero) begin
        n_nxt.nrm[i] = (i == 0) ? ONE : 32'd0;
      end else if (n_nxt.dsign[i]) begin
        n_nxt.nrm[i] = 32'd0 - 32'(quo[i]);
      end else begin
        n_nxt.nrm[i] = 32'(quo[i]);
      end
    end
  end

  // Stage M: normal scaled by each radius.
  always_comb begin
    m_nxt = n_r;
    for (int i = 0; i < 3; i++) begin
      m_nxt.m1[i] = spc_pkg::mul64($signed(n_r.nrm[i]), n_r.r1);
      m_nxt.m2[i] = spc_pkg::mul64($signed(n_r.nrm[i]), n_r.r2);
    end
  end

  // Output stage: pick the result of the pair type, zero on a miss.
  always_comb begin
    logic [2:0][31:0] nv, pa, pb;
    nv = '0;
    pa = '0;
    pb = '0;
    out_nxt = '0;
    if (m_r.mode_ss && m_r.hit_ss) begin
      out_nxt.hit   = 1'b1;
      out_nxt.depth = m_r.depth_ss;
      for (int i = 0; i < 3; i++) begin
        nv[i] = m_r.nrm[i];
        pa[i] = spc_pkg::sat32(spc_pkg::ext66($signed(m_r.c1[i])) +
                  spc_pkg::wext66($signed(m_r.m1[i]) >>> FRAC_BITS));
        pb[i] = spc_pkg::sat32(spc_pkg::ext66($signed(m_r.c2[i])) -
                  spc_pkg::wext66($signed(m_r.m2[i]) >>> FRAC_BITS));
      end
    end else if (m_r.mode_sp && m_r.hit_sp) begin
      out_nxt.hit   = 1'b1;
      out_nxt.depth = m_r.depth_sp;
      for (int i = 0; i < 3; i++) begin
        nv[i] = m_r.neg ? spc_pkg::sat32(-spc_pkg::ext66($signed(m_r.n_pl[i])))
                        : m_r.n_pl[i];
        pa[i] = m_r.pt_pl[i];
        pb[i] = m_r.pt_pl[i];
      end
    end
    out_nxt.normal_x       = nv[0];
    out_nxt.normal_y       = nv[1];
    out_nxt.normal_z       = nv[2];
    out_nxt.point_first_x  = pa[0];
    out_nxt.point_first_y  = pa[1];
    out_nxt.point_first_z  = pa[2];
    out_nxt.point_second_x = pb[0];
    out_nxt.point_second_y = pb[1];
    out_nxt.point_second_z = pb[2];
  end

  always_ff @(posedge clk) begin
    st1_r    <= st1_nxt;
    st2_r    <= st2_nxt;
    st3_r    <= st3_nxt;
    dl1_r[0] <= st3_r;
    for (int i = 1; i < SQ_LAT; i++) begin
      dl1_r[i] <= dl1_r[i-1];
    end
    e_r      <= e_nxt;
    dl2_r[0] <= e_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      dl2_r[i] <= dl2_r[i-1];
    end
    n_r   <= n_nxt;
    m_r   <= m_nxt;
    out_r <= out_nxt;
  end

  // Valid bits travel alongside the beats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      ve_r     <= 1'b0;
      vn_r     <= 1'b0;
      vm_r     <= 1'b0;
      strobe_r <= 1'b0;
      for (int i = 0; i < SQ_LAT; i++) begin
        vd1_r[i] <= 1'b0;
      end
      for (int i = 0; i < DIV_LAT; i++) begin
        vd2_r[i] <= 1'b0;
      end
    end else begin
      v1_r     <= start && !busy;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      vd1_r[0] <= v3_r;
      for (int i = 1; i < SQ_LAT; i++) begin
        vd1_r[i] <= vd1_r[i-1];
      end
      ve_r     <= vd1_r[SQ_LAT-1];
      vd2_r[0] <= ve_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        vd2_r[i] <= vd2_r[i-1];
      end
      vn_r     <= vd2_r[DIV_LAT-1];
      vm_r     <= vn_r;
      strobe_r <= vm_r;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

>>> design/spc_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module spc_isqrt (
  input  logic        clk,
  input  logic [63:0] rad_in,
  output logic [31:0] root_out
);

  localparam int STEPS = 32;

  logic [63:0] v_r   [1:STEPS];
  logic [63:0] res_r [1:STEPS];

  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] v_in, res_in, trial, v_nxt, res_nxt;

      if (k == 0) begin : g_first
        assign v_in   = rad_in;
        assign res_in = '0;
      end else begin : g_next
        assign v_in   = v_r[k];
        assign res_in = res_r[k];
      end

      always_comb begin
        trial = res_in + BIT;
        if (v_in >= trial) begin
          v_nxt   = v_in - trial;
          res_nxt = (res_in >> 1) + BIT;
        end else begin
          v_nxt   = v_in;
          res_nxt = res_in >> 1;
        end
      end

      always_ff @(posedge clk) begin
        v_r[k+1]   <= v_nxt;
        res_r[k+1] <= res_nxt;
      end
    end
  endgenerate

  assign root_out = res_r[STEPS][31:0];

endmodule

>>> design/spc_div.sv
// ----------------------------------------------------------------------------
// Pipelined normal divider
// Quotient (num << FRAC_BITS) / den for num <= den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module spc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [31:0]          num_in,
  input  logic [31:0]          den_in,
  output logic [FRAC_BITS:0]   quo_out
);

  localparam int STEPS = FRAC_BITS + 1;

  logic [31:0]        den_r [0:STEPS-1];
  logic [31:0]        rem_r [0:STEPS-1];
  logic [FRAC_BITS:0] quo_r [0:STEPS-1];

  genvar s;
  generate
    for (s = 0; s < STEPS; s++) begin : g_step
      logic [32:0]        trial;
      logic [31:0]        den_in_s;
      logic [31:0]        rem_nxt;
      logic [FRAC_BITS:0] quo_in, quo_nxt;

      // The first step sees the numerator itself; later steps shift in a zero.
      if (s == 0) begin : g_first
        assign trial    = {1'b0, num_in};
        assign den_in_s = den_in;
        assign quo_in   = '0;
      end else begin : g_next
        assign trial    = {rem_r[s-1], 1'b0};
        assign den_in_s = den_r[s-1];
        assign quo_in   = quo_r[s-1];
      end

      always_comb begin
        if (trial >= {1'b0, den_in_s}) begin
          rem_nxt = 32'(trial - {1'b0, den_in_s});
          quo_nxt = {quo_in[FRAC_BITS-1:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_in[FRAC_BITS-1:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        den_r[s] <= den_in_s;
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
      end
    end
  endgenerate

  assign quo_out = quo_r[STEPS-1];

endmodule

>>> design/spc_checker.sv
// ----------------------------------------------------------------------------
// Sphere/plane contact test port checker
// Watches the top level ports for result timing and result consistency.
// ----------------------------------------------------------------------------
module spc_checker #(
  parameter int LAT = 56
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input spc_pkg::in_beat_t  in_data,
  input logic               out_strobe,
  input spc_pkg::out_beat_t out_data
);

  logic unused_in;
  assign unused_in = ^in_data;

  // The block never holds off the command side.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Every result beat follows an accepted command beat by the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result beat without matching command beat");

  // A miss reports zero depth, a zero normal and zero x coordinates for both points.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.hit) |->
      (out_data.depth == 0 && out_data.normal_x == 0 && out_data.normal_y == 0 &&
       out_data.normal_z == 0 && out_data.point_first_x == 0 &&
       out_data.point_second_x == 0))
    else $error("nonzero fields on a miss");

  // A strobed result beat carries fully known data.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown(out_data))
    else $error("unknown bits in a result beat");

endmodule

bind sphere_plane_contact_test_core spc_checker #(.LAT(LATENCY)) u_spc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
